@@ src/mf5_pkg.sv @@
// Shared constants, types and helpers of the 5x5 RGB median filter.
package mf5_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int CHANNELS   = 3;
   localparam int HEIGHT_MAX = 4096;

   localparam int NUM_CH     = 3;
   localparam int CH_W       = 8;
   localparam int PIX_W      = NUM_CH * CH_W;
   localparam int WIN_N      = 5;
   localparam int WIN_TAPS   = WIN_N * WIN_N;
   localparam int MED_RANK   = 12;
   localparam int ROW_SLOTS  = 8;
   localparam int SLOT_W     = $clog2(ROW_SLOTS);
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int WID_W      = $clog2(MAX_WIDTH + 1);
   localparam int HGT_W      = $clog2(HEIGHT_MAX + 1);
   localparam int ROW_W      = $clog2(HEIGHT_MAX);
   localparam int CFG_WID_W  = 9;
   localparam int CFG_HGT_W  = 13;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 13;
   localparam int LANE_LAT   = 4;
   localparam int OUTQ_DEPTH = 16;
   localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_HEIGHT = 1'd1;

   localparam logic REQ_PIXEL = 1'b0;
   localparam logic REQ_DRAIN = 1'b1;

   localparam logic signed [HGT_W+1:0] MIR_ONE = 1;

   // what a column fetch does to the window once it lands
   typedef enum logic [2:0] {
      WIN_HOLD,
      WIN_START,
      WIN_FETCH,
      WIN_COPY3,
      WIN_COPY1
   } win_op_type;

   // which next-row preload column a fetch fills
   typedef enum logic [1:0] {
      PRE_NONE,
      PRE_P0,
      PRE_P1
   } pre_op_type;

   typedef logic [PIX_W-1:0] pix_type;
   typedef logic [WIN_N-1:0][PIX_W-1:0] column_type;
   typedef logic [WIN_N-1:0][WIN_N-1:0][PIX_W-1:0] win_type;   // [col][row]
   typedef logic [WIN_TAPS-1:0][CH_W-1:0] taps_type;
   typedef logic [NUM_CH-1:0][CH_W-1:0] med_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] slot;
      logic [COL_W-1:0]  col;
      pix_type           data;
   } wr_type;

   typedef struct packed {
      logic                          vld;
      logic                          emit;
      logic                          fe;
      win_op_type                    op;
      pre_op_type                    pre;
      logic [COL_W-1:0]              col;
      logic [WIN_N-1:0][SLOT_W-1:0]  slot;
   } job_type;

   typedef struct packed {
      logic vld;
      logic fe;
   } tag_type;

   // line-store slot of row+off, mirrored into [0, n) without repeating the edge
   function automatic logic [SLOT_W-1:0] mirror_slot(input logic [HGT_W-1:0] row,
                                                     input logic signed [2:0] off,
                                                     input logic [HGT_W-1:0] n);
      logic signed [HGT_W+1:0] x;
      logic signed [HGT_W+1:0] nn;
      x  = $signed({2'b00, row}) + $signed({{(HGT_W-1){off[2]}}, off});
      nn = $signed({2'b00, n});
      if (x < 0) x = -x;
      if (x >= nn) x = ((nn - MIR_ONE) <<< 1) - x;
      return x[SLOT_W-1:0];
   endfunction

endpackage

@@ src/mf5_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mf5_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rd_ff <= mem_ff[raddr];
   end

   assign rdata = rd_ff;

endmodule

@@ src/mf5_ctrl.sv @@
// Config registers, raster counters and per-item fetch job generation.
module mf5_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [mf5_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mf5_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  logic                             req_type,
   input  logic [mf5_pkg::CH_W-1:0]         req_red_in,
   input  logic [mf5_pkg::CH_W-1:0]         req_green_in,
   input  logic [mf5_pkg::CH_W-1:0]         req_blue_in,
   output mf5_pkg::wr_type                  wr,
   output mf5_pkg::job_type                 job,
   output logic                             emit_accept
);

   logic [mf5_pkg::CFG_WID_W-1:0] width_ff, width_in;
   logic [mf5_pkg::CFG_HGT_W-1:0] height_ff, height_in;
   logic [mf5_pkg::COL_W-1:0]     in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [mf5_pkg::ROW_W-1:0]     in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic                          drain_ff, drain_in;
   mf5_pkg::job_type              job_ff, job_in;

   logic [mf5_pkg::WID_W-1:0] w_eff, oc;
   logic [mf5_pkg::HGT_W-1:0] h_eff, r_sel;
   logic accept, is_drain, pix, primed, emit, restart;
   logic in_col_last, in_row_last, out_col_last, out_row_last;

   // clamp registers into their usable ranges
   always_comb begin
      if (width_ff < 3) w_eff = mf5_pkg::WID_W'(3);
      else if (width_ff > mf5_pkg::MAX_WIDTH) w_eff = mf5_pkg::WID_W'(mf5_pkg::MAX_WIDTH);
      else w_eff = mf5_pkg::WID_W'(width_ff);
      if (height_ff < 3) h_eff = mf5_pkg::HGT_W'(3);
      else if (height_ff > mf5_pkg::HEIGHT_MAX) h_eff = mf5_pkg::HGT_W'(mf5_pkg::HEIGHT_MAX);
      else h_eff = mf5_pkg::HGT_W'(height_ff);
   end

   assign accept   = req_valid & req_ready;
   assign is_drain = (req_type == mf5_pkg::REQ_DRAIN);
   assign pix      = accept & ~is_drain & ~drain_ff;
   assign primed   = (in_row_ff > mf5_pkg::ROW_W'(2)) ||
                     (in_row_ff == mf5_pkg::ROW_W'(2) && in_col_ff >= mf5_pkg::COL_W'(2));
   assign emit     = accept & ((is_drain & drain_ff) | (pix & primed));
   assign emit_accept = emit;

   assign in_col_last  = mf5_pkg::WID_W'(in_col_ff) == w_eff - mf5_pkg::WID_W'(1);
   assign in_row_last  = mf5_pkg::HGT_W'(in_row_ff) == h_eff - mf5_pkg::HGT_W'(1);
   assign out_col_last = mf5_pkg::WID_W'(out_col_ff) == w_eff - mf5_pkg::WID_W'(1);
   assign out_row_last = mf5_pkg::HGT_W'(out_row_ff) == h_eff - mf5_pkg::HGT_W'(1);
   assign oc = mf5_pkg::WID_W'(out_col_ff);

   // line store write of the incoming pixel
   always_comb begin
      wr.en   = pix;
      wr.slot = in_row_ff[mf5_pkg::SLOT_W-1:0];
      wr.col  = in_col_ff;
      wr.data = {req_blue_in, req_green_in, req_red_in};
   end

   // fetch job: one column of five rows per released output, or a preload column on the first output row
   always_comb begin
      job_in      = '0;
      job_in.op   = mf5_pkg::WIN_HOLD;
      job_in.pre  = mf5_pkg::PRE_NONE;
      r_sel       = '0;
      if (emit) begin
         job_in.vld  = 1'b1;
         job_in.emit = 1'b1;
         job_in.fe   = out_row_last & out_col_last;
         r_sel       = mf5_pkg::HGT_W'(out_row_ff);
         if (out_col_ff == '0) begin
            job_in.op  = mf5_pkg::WIN_START;
            job_in.col = mf5_pkg::COL_W'(2);
         end else if (oc + mf5_pkg::WID_W'(3) <= w_eff) begin
            job_in.op  = mf5_pkg::WIN_FETCH;
            job_in.col = out_col_ff + mf5_pkg::COL_W'(2);
         end else if (oc + mf5_pkg::WID_W'(2) == w_eff) begin
            // right edge: window reuses its own column, port preloads next row
            job_in.op  = mf5_pkg::WIN_COPY3;
            job_in.pre = mf5_pkg::PRE_P0;
            job_in.col = '0;
            r_sel      = mf5_pkg::HGT_W'(out_row_ff) + mf5_pkg::HGT_W'(1);
         end else begin
            job_in.op  = mf5_pkg::WIN_COPY1;
            job_in.pre = mf5_pkg::PRE_P1;
            job_in.col = mf5_pkg::COL_W'(1);
            r_sel      = mf5_pkg::HGT_W'(out_row_ff) + mf5_pkg::HGT_W'(1);
         end
      end else if (pix && in_row_ff == mf5_pkg::ROW_W'(2) && in_col_ff < mf5_pkg::COL_W'(2)) begin
         // first output row has no previous row to preload its left columns
         job_in.vld = 1'b1;
         job_in.pre = (in_col_ff == '0) ? mf5_pkg::PRE_P0 : mf5_pkg::PRE_P1;
         job_in.col = in_col_ff;
      end
      for (int k = 0; k < mf5_pkg::WIN_N; k++) begin
         job_in.slot[k] = mf5_pkg::mirror_slot(r_sel, 3'(k - 2), h_eff);
      end
   end

   // registers and raster position
   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      drain_in   = drain_ff;
      restart    = 1'b0;
      if (csr_we) begin
         case (csr_index)
            mf5_pkg::CSR_IMAGE_WIDTH: begin
               width_in = csr_wdata[mf5_pkg::CFG_WID_W-1:0];
               restart  = 1'b1;
            end
            mf5_pkg::CSR_IMAGE_HEIGHT: begin
               height_in = csr_wdata[mf5_pkg::CFG_HGT_W-1:0];
               restart   = 1'b1;
            end
            default: ;
         endcase
      end
      if (restart) begin
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
         drain_in   = 1'b0;
      end else begin
         if (pix) begin
            if (in_col_last) begin
               in_col_in = '0;
               if (in_row_last) begin
                  in_row_in = '0;
                  drain_in  = 1'b1;
               end else begin
                  in_row_in = in_row_ff + mf5_pkg::ROW_W'(1);
               end
            end else begin
               in_col_in = in_col_ff + mf5_pkg::COL_W'(1);
            end
         end
         if (emit) begin
            if (out_col_last) begin
               out_col_in = '0;
               if (out_row_last) begin
                  out_row_in = '0;
                  drain_in   = 1'b0;
               end else begin
                  out_row_in = out_row_ff + mf5_pkg::ROW_W'(1);
               end
            end else begin
               out_col_in = out_col_ff + mf5_pkg::COL_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= mf5_pkg::CFG_WID_W'(256);
         height_ff  <= mf5_pkg::CFG_HGT_W'(256);
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         drain_ff   <= 1'b0;
         job_ff     <= '0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         drain_ff   <= drain_in;
         job_ff     <= job_in;
      end
   end

   assign job = job_ff;

endmodule

@@ src/mf5_window.sv @@
// Eight-bank line store and the 5x5 window shift registers.
module mf5_window (
   input  logic              clock,
   input  logic              reset,
   input  mf5_pkg::wr_type   wr,
   input  mf5_pkg::job_type  job,
   output mf5_pkg::win_type  win,
   output mf5_pkg::tag_type  tag
);

   mf5_pkg::pix_type    bank_q [mf5_pkg::ROW_SLOTS];
   mf5_pkg::job_type    s2_ff;
   mf5_pkg::column_type colv;
   mf5_pkg::win_type    win_ff, win_in;
   mf5_pkg::column_type p0_ff, p0_in, p1_ff, p1_in;
   mf5_pkg::tag_type    tag_ff, tag_in;

   for (genvar b = 0; b < mf5_pkg::ROW_SLOTS; b++) begin : g_bank
      mf5_ram #(
         .WIDTH (mf5_pkg::PIX_W),
         .DEPTH (mf5_pkg::MAX_WIDTH)
      ) u_ram (
         .clock (clock),
         .we    (wr.en && wr.slot == mf5_pkg::SLOT_W'(b)),
         .waddr (wr.col),
         .wdata (wr.data),
         .raddr (job.col),
         .rdata (bank_q[b])
      );
   end

   always_comb begin
      for (int k = 0; k < mf5_pkg::WIN_N; k++) colv[k] = bank_q[s2_ff.slot[k]];
   end

   always_comb begin
      win_in = win_ff;
      p0_in  = p0_ff;
      p1_in  = p1_ff;
      if (s2_ff.vld) begin
         case (s2_ff.op)
            mf5_pkg::WIN_START: begin
               // columns 2,1,0,1,2 around the left edge
               win_in[0] = colv;
               win_in[1] = p1_ff;
               win_in[2] = p0_ff;
               win_in[3] = p1_ff;
               win_in[4] = colv;
            end
            mf5_pkg::WIN_FETCH, mf5_pkg::WIN_COPY3, mf5_pkg::WIN_COPY1: begin
               for (int k = 0; k < mf5_pkg::WIN_N - 1; k++) win_in[k] = win_ff[k+1];
               if (s2_ff.op == mf5_pkg::WIN_FETCH) win_in[4] = colv;
               else if (s2_ff.op == mf5_pkg::WIN_COPY3) win_in[4] = win_ff[3];
               else win_in[4] = win_ff[1];
            end
            default: ;
         endcase
         case (s2_ff.pre)
            mf5_pkg::PRE_P0: p0_in = colv;
            mf5_pkg::PRE_P1: p1_in = colv;
            default: ;
         endcase
      end
      tag_in.vld = s2_ff.vld & s2_ff.emit;
      tag_in.fe  = s2_ff.fe;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff  <= '0;
         tag_ff <= '0;
      end else begin
         s2_ff  <= job;
         tag_ff <= tag_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      p0_ff  <= p0_in;
      p1_ff  <= p1_in;
   end

   assign win = win_ff;
   assign tag = tag_ff;

endmodule

@@ src/mf5_lane.sv @@
// One channel lane: rank-based median of 25 samples in four stages.
module mf5_lane (
   input  logic                       clock,
   input  mf5_pkg::taps_type          taps,
   output logic [mf5_pkg::CH_W-1:0]   med
);

   mf5_pkg::taps_type val_a_ff, val_b_ff, val_c_ff;
   logic [mf5_pkg::WIN_TAPS-1:0][mf5_pkg::WIN_TAPS-1:0] lt_a_ff, lt_a_in;
   logic [mf5_pkg::WIN_TAPS-1:0][2:0][3:0] cnt_b_ff, cnt_b_in;
   logic [mf5_pkg::WIN_TAPS-1:0] sel_c_ff, sel_c_in;
   logic [mf5_pkg::CH_W-1:0] med_ff, med_in;
   logic [4:0] rank [mf5_pkg::WIN_TAPS];

   // stage a: j counts below i when smaller, ties broken by position
   always_comb begin
      for (int i = 0; i < mf5_pkg::WIN_TAPS; i++) begin
         for (int j = 0; j < mf5_pkg::WIN_TAPS; j++) begin
            lt_a_in[i][j] = (j != i) &&
                            ((taps[j] < taps[i]) || (taps[j] == taps[i] && j < i));
         end
      end
   end

   // stage b: partial counts over three groups
   always_comb begin
      for (int i = 0; i < mf5_pkg::WIN_TAPS; i++) begin
         cnt_b_in[i] = '0;
         for (int j = 0; j < 8; j++)
            cnt_b_in[i][0] = cnt_b_in[i][0] + 4'(lt_a_ff[i][j]);
         for (int j = 8; j < 16; j++)
            cnt_b_in[i][1] = cnt_b_in[i][1] + 4'(lt_a_ff[i][j]);
         for (int j = 16; j < mf5_pkg::WIN_TAPS; j++)
            cnt_b_in[i][2] = cnt_b_in[i][2] + 4'(lt_a_ff[i][j]);
      end
   end

   // stage c: rank and match against the middle
   always_comb begin
      for (int i = 0; i < mf5_pkg::WIN_TAPS; i++) begin
         rank[i] = 5'(cnt_b_ff[i][0]) + 5'(cnt_b_ff[i][1]) + 5'(cnt_b_ff[i][2]);
         sel_c_in[i] = (rank[i] == 5'(mf5_pkg::MED_RANK));
      end
   end

   // stage d: one-hot select
   always_comb begin
      med_in = '0;
      for (int i = 0; i < mf5_pkg::WIN_TAPS; i++)
         med_in = med_in | (sel_c_ff[i] ? val_c_ff[i] : '0);
   end

   always_ff @(posedge clock) begin
      val_a_ff <= taps;
      lt_a_ff  <= lt_a_in;
      val_b_ff <= val_a_ff;
      cnt_b_ff <= cnt_b_in;
      val_c_ff <= val_b_ff;
      sel_c_ff <= sel_c_in;
      med_ff   <= med_in;
   end

   assign med = med_ff;

endmodule

@@ src/mf5_outq.sv @@
// Merges lane results with frame tags into the output queue.
module mf5_outq (
   input  logic                       clock,
   input  logic                       reset,
   input  mf5_pkg::tag_type           tag,
   input  mf5_pkg::med_type           med,
   input  logic                       emit_accept,
   input  logic                       rsp_ready,
   output logic                       rsp_valid,
   output logic [mf5_pkg::CH_W-1:0]   rsp_red_out,
   output logic [mf5_pkg::CH_W-1:0]   rsp_green_out,
   output logic [mf5_pkg::CH_W-1:0]   rsp_blue_out,
   output logic                       rsp_frame_end,
   output logic                       room
);

   typedef struct packed {
      logic             fe;
      mf5_pkg::med_type px;
   } ent_type;

   mf5_pkg::tag_type [mf5_pkg::LANE_LAT-1:0] dly_ff, dly_in;
   ent_type q_ff [mf5_pkg::OUTQ_DEPTH];
   ent_type ent_in, head;
   logic [mf5_pkg::OUTQ_PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [mf5_pkg::OUTQ_CNT_W-1:0] cnt_ff, cnt_in, res_ff, res_in;
   logic push, pop;

   assign dly_in = {dly_ff[mf5_pkg::LANE_LAT-2:0], tag};
   assign push   = dly_ff[mf5_pkg::LANE_LAT-1].vld;
   assign pop    = rsp_valid & rsp_ready;

   always_comb begin
      ent_in.fe = dly_ff[mf5_pkg::LANE_LAT-1].fe;
      ent_in.px = med;
   end

   // reservation covers items in the pipe plus queued ones
   assign room      = res_ff < mf5_pkg::OUTQ_CNT_W'(mf5_pkg::OUTQ_DEPTH);
   assign res_in    = res_ff + mf5_pkg::OUTQ_CNT_W'(emit_accept) - mf5_pkg::OUTQ_CNT_W'(pop);
   assign cnt_in    = cnt_ff + mf5_pkg::OUTQ_CNT_W'(push) - mf5_pkg::OUTQ_CNT_W'(pop);
   assign wr_ptr_in = wr_ptr_ff + mf5_pkg::OUTQ_PTR_W'(push);
   assign rd_ptr_in = rd_ptr_ff + mf5_pkg::OUTQ_PTR_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         dly_ff    <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
         res_ff    <= '0;
      end else begin
         dly_ff    <= dly_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
         res_ff    <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= ent_in;
   end

   assign head          = q_ff[rd_ptr_ff];
   assign rsp_valid     = cnt_ff != '0;
   assign rsp_red_out   = head.px[0];
   assign rsp_green_out = head.px[1];
   assign rsp_blue_out  = head.px[2];
   assign rsp_frame_end = head.fe;

endmodule

@@ src/median_filter_5x5_rgb_top.sv @@
// Top level of the streaming 5x5 RGB median filter.
// A released result passes the job, window, lane and output queue registers.
// Throughput: one item per cycle while ready is high; each item costs one
// five-row column read from the eight line-store banks, and each channel
// lane is fully pipelined. Ready drops while 16 results are in flight or queued.
// Reset: synchronous; clears counters, queue and sets the frame size to 256x256.
module median_filter_5x5_rgb_top (
   input  logic                             clock,
   input  logic                             reset,
   // configuration writes
   input  logic                             csr_we,
   input  logic [mf5_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mf5_pkg::CSR_DATA_W-1:0]   csr_wdata,
   // pixel / drain input
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_type,
   input  logic [mf5_pkg::CH_W-1:0]         req_red_in,
   input  logic [mf5_pkg::CH_W-1:0]         req_green_in,
   input  logic [mf5_pkg::CH_W-1:0]         req_blue_in,
   // filtered output
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [mf5_pkg::CH_W-1:0]         rsp_red_out,
   output logic [mf5_pkg::CH_W-1:0]         rsp_green_out,
   output logic [mf5_pkg::CH_W-1:0]         rsp_blue_out,
   output logic                             rsp_frame_end
);

   mf5_pkg::wr_type   wr;
   mf5_pkg::job_type  job;
   mf5_pkg::win_type  win;
   mf5_pkg::tag_type  tag;
   mf5_pkg::med_type  med;
   logic              emit_accept;
   logic              room;

   assign req_ready = room;

   // Raster counters decide per transfer whether an output is released and
   // which column of the line store the window needs next.
   mf5_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_type     (req_type),
      .req_red_in   (req_red_in),
      .req_green_in (req_green_in),
      .req_blue_in  (req_blue_in),
      .wr           (wr),
      .job          (job),
      .emit_accept  (emit_accept)
   );

   // Line store plus window: the window shifts one column per output; at
   // the left edge it is rebuilt from two preloaded columns, at the right
   // edge it reuses its own columns (mirror without edge repeat).
   mf5_window u_window (
      .clock (clock),
      .reset (reset),
      .wr    (wr),
      .job   (job),
      .win   (win),
      .tag   (tag)
   );

   // One median lane per channel, all working on the same window.
   for (genvar ch = 0; ch < mf5_pkg::NUM_CH; ch++) begin : g_lane
      if (ch < mf5_pkg::CHANNELS) begin : g_on
         mf5_pkg::taps_type taps;
         for (genvar r = 0; r < mf5_pkg::WIN_N; r++) begin : g_r
            for (genvar c = 0; c < mf5_pkg::WIN_N; c++) begin : g_c
               assign taps[r*mf5_pkg::WIN_N + c] = win[c][r][ch*mf5_pkg::CH_W +: mf5_pkg::CH_W];
            end
         end
         mf5_lane u_lane (
            .clock (clock),
            .taps  (taps),
            .med   (med[ch])
         );
      end else begin : g_off
         assign med[ch] = '0;
      end
   end

   // Merge lanes with the frame tag and queue results for the consumer.
   mf5_outq u_outq (
      .clock         (clock),
      .reset         (reset),
      .tag           (tag),
      .med           (med),
      .emit_accept   (emit_accept),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_frame_end (rsp_frame_end),
      .room          (room)
   );

endmodule

@@ test/tb_top.sv @@
// Self-checking testbench for the streaming 5x5 RGB median filter.
module tb_top;

   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE      = 16;    // margin for results still in flight
   localparam int HOLD_LEN    = 400;   // long receiver stall for back-pressure

   logic                           clock;
   logic                           reset;
   logic                           csr_we;
   logic [mf5_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [mf5_pkg::CSR_DATA_W-1:0] csr_wdata;
   logic                           req_valid;
   logic                           req_ready;
   logic                           req_type;
   logic [mf5_pkg::CH_W-1:0]       req_red_in;
   logic [mf5_pkg::CH_W-1:0]       req_green_in;
   logic [mf5_pkg::CH_W-1:0]       req_blue_in;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [mf5_pkg::CH_W-1:0]       rsp_red_out;
   logic [mf5_pkg::CH_W-1:0]       rsp_green_out;
   logic [mf5_pkg::CH_W-1:0]       rsp_blue_out;
   logic                           rsp_frame_end;

   median_filter_5x5_rgb_top u_dut (.*);

   // one filtered pixel as it should leave the block
   typedef struct {
      logic [mf5_pkg::CH_W-1:0] red;
      logic [mf5_pkg::CH_W-1:0] green;
      logic [mf5_pkg::CH_W-1:0] blue;
      logic                     fe;
   } pixel_out_type;

   pixel_out_type pending_pixels[$];
   int            fail_count = 0;
   int            cycle_count = 0;
   logic          hold_req;
   logic          hold_rsp;
   int            stall_left;

   // --- filter state, kept alongside the block -------------------------------
   mf5_pkg::pix_type              lines [mf5_pkg::ROW_SLOTS][mf5_pkg::MAX_WIDTH];
   logic [mf5_pkg::CFG_WID_W-1:0] width_reg;
   logic [mf5_pkg::CFG_HGT_W-1:0] height_reg;
   int                            in_r, in_c, out_r, out_c;
   bit                            tail_open;   // frame fully received, outputs still owed

   function automatic int cur_width();
      int w;
      w = width_reg;
      if (w < 3) w = 3;
      if (w > mf5_pkg::MAX_WIDTH) w = mf5_pkg::MAX_WIDTH;
      return w;
   endfunction

   function automatic int cur_height();
      int h;
      h = height_reg;
      if (h < 3) h = 3;
      if (h > mf5_pkg::HEIGHT_MAX) h = mf5_pkg::HEIGHT_MAX;
      return h;
   endfunction

   function automatic int reflect(int pos, int off, int n);
      int x;
      x = pos + off;
      if (x < 0) x = -x;
      if (x >= n) x = 2 * (n - 1) - x;
      return x;
   endfunction

   function automatic logic [mf5_pkg::CH_W-1:0] median_of(int ch);
      logic [mf5_pkg::CH_W-1:0] v[25];
      logic [mf5_pkg::CH_W-1:0] t;
      int k, j, h, w;
      h = cur_height();
      w = cur_width();
      k = 0;
      for (int dr = -2; dr <= 2; dr++)
         for (int dc = -2; dc <= 2; dc++) begin
            v[k] = lines[reflect(out_r, dr, h) % mf5_pkg::ROW_SLOTS][reflect(out_c, dc, w)]
                   [ch*mf5_pkg::CH_W +: mf5_pkg::CH_W];
            k++;
         end
      for (int i = 1; i < 25; i++) begin
         t = v[i];
         j = i - 1;
         while (j >= 0 && v[j] > t) begin
            v[j+1] = v[j];
            j--;
         end
         v[j+1] = t;
      end
      return v[mf5_pkg::MED_RANK];
   endfunction

   function automatic pixel_out_type next_output();
      pixel_out_type o;
      int w, h;
      w = cur_width();
      h = cur_height();
      o.red   = (mf5_pkg::CHANNELS > 0) ? median_of(0) : '0;
      o.green = (mf5_pkg::CHANNELS > 1) ? median_of(1) : '0;
      o.blue  = (mf5_pkg::CHANNELS > 2) ? median_of(2) : '0;
      o.fe    = (out_r == h - 1 && out_c == w - 1);
      out_c++;
      if (out_c >= w) begin
         out_c = 0;
         out_r++;
         if (out_r >= h) begin
            out_r = 0;
            tail_open = 0;
         end
      end
      return o;
   endfunction

   // returns 1 when the transfer releases a filtered pixel
   function automatic bit filter_step(logic typ, logic [7:0] r, logic [7:0] g,
                                      logic [7:0] b, output pixel_out_type o);
      int w, h, p;
      w = cur_width();
      h = cur_height();
      o = '{default: '0};
      if (typ == mf5_pkg::REQ_DRAIN) begin
         if (!tail_open) return 0;
         o = next_output();
         return 1;
      end
      if (tail_open) return 0;
      lines[in_r % mf5_pkg::ROW_SLOTS][in_c] = {b, g, r};
      p = in_r * w + in_c;
      in_c++;
      if (in_c >= w) begin
         in_c = 0;
         in_r++;
         if (in_r >= h) begin
            in_r = 0;
            tail_open = 1;
         end
      end
      if (p >= 2 * w + 2) begin
         o = next_output();
         return 1;
      end
      return 0;
   endfunction

   function automatic void frame_restart();
      in_r = 0; in_c = 0; out_r = 0; out_c = 0;
      tail_open = 0;
   endfunction

   // --- clock, reset, timeout -------------------------------------------------
   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic report(string what, int got, int want);
      $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got, want);
      fail_count++;
   endtask

   // --- result side: random stalls plus one long hold-off --------------------
   always @(posedge clock) begin
      pixel_out_type e;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_pixels.size() == 0) begin
               report("unexpected transfer", 1, 0);
            end else begin
               e = pending_pixels.pop_front();
               if (rsp_red_out   !== e.red)   report("red",   rsp_red_out,   e.red);
               if (rsp_green_out !== e.green) report("green", rsp_green_out, e.green);
               if (rsp_blue_out  !== e.blue)  report("blue",  rsp_blue_out,  e.blue);
               if (rsp_frame_end !== e.fe)    report("frame_end", rsp_frame_end, e.fe);
            end
         end
         // mostly no stall, now and then a short one, rarely a long one
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            case ($urandom_range(0, 19))
               0, 1, 2: stall_left = $urandom_range(0, 2);
               3:       stall_left = $urandom_range(10, 40);
               default: stall_left = 0;
            endcase
            rsp_ready <= (stall_left == 0);
         end
      end
   end

   // the hold-off is timed here, independent of the sender
   initial begin
      hold_rsp = 1'b0;
      wait (hold_req);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_LEN) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // --- sender helpers --------------------------------------------------------
   // Called at a rising edge; returns at the edge where the transfer happened.
   task automatic send_item(logic typ, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                            bit use_given = 0, pixel_out_type given = '{default: '0});
      pixel_out_type o;
      bit            has;
      req_valid    <= 1'b1;
      req_type     <= typ;
      req_red_in   <= r;
      req_green_in <= g;
      req_blue_in  <= b;
      do @(posedge clock); while (!req_ready);
      has = filter_step(typ, r, g, b, o);
      if (use_given) begin
         if (!has) report("table row expects a transfer", 0, 1);
         pending_pixels.push_back(given);
      end else if (has) begin
         pending_pixels.push_back(o);
      end
   endtask

   task automatic sender_gap();
      int g;
      case ($urandom_range(0, 19))
         0, 1, 2, 3: g = $urandom_range(1, 3);
         4:          g = $urandom_range(10, 30);
         default:    g = 0;
      endcase
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // block must be empty before a register write
   task automatic wait_idle();
      req_valid <= 1'b0;
      wait (pending_pixels.size() == 0);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [mf5_pkg::CSR_IDX_W-1:0] idx,
                            logic [mf5_pkg::CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == mf5_pkg::CSR_IMAGE_WIDTH) width_reg = val[mf5_pkg::CFG_WID_W-1:0];
      else                                 height_reg = val[mf5_pkg::CFG_HGT_W-1:0];
      frame_restart();
      @(posedge clock);
   endtask

   function automatic logic [7:0] rand_sample();
      case ($urandom_range(0, 9))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // a full frame with random content, stray drains and stray pixels mixed in
   task automatic run_frame();
      int w, h;
      w = cur_width();
      h = cur_height();
      for (int p = 0; p < w * h; p++) begin
         if ($urandom_range(0, 29) == 0) begin
            send_item(mf5_pkg::REQ_DRAIN, rand_sample(), rand_sample(), rand_sample());
            sender_gap();
         end
         send_item(mf5_pkg::REQ_PIXEL, rand_sample(), rand_sample(), rand_sample());
         sender_gap();
      end
      for (int d = 0; d < 2 * w + 2; d++) begin
         if ($urandom_range(0, 29) == 0) begin
            send_item(mf5_pkg::REQ_PIXEL, rand_sample(), rand_sample(), rand_sample());
            sender_gap();
         end
         send_item(mf5_pkg::REQ_DRAIN, rand_sample(), rand_sample(), rand_sample());
         sender_gap();
      end
   endtask

   // part of a frame only; the next register write throws the rest away
   task automatic run_partial(int n);
      for (int p = 0; p < n; p++) begin
         send_item($urandom_range(0, 9) == 0 ? mf5_pkg::REQ_DRAIN : mf5_pkg::REQ_PIXEL,
                   rand_sample(), rand_sample(), rand_sample());
         sender_gap();
      end
   endtask

   // --- directed table: one 3x3 frame of a flat color -------------------------
   typedef struct {
      logic          typ;
      logic [7:0]    r, g, b;
      bit            known;
      pixel_out_type want;
   } table_row_type;

   localparam pixel_out_type FLAT    = '{8'hFF, 8'h00, 8'h80, 1'b0};
   localparam pixel_out_type FLAT_FE = '{8'hFF, 8'h00, 8'h80, 1'b1};
   localparam pixel_out_type NONE    = '{8'h00, 8'h00, 8'h00, 1'b0};

   table_row_type plan[20] = '{
      // drain with no tail open: nothing comes out
      '{mf5_pkg::REQ_DRAIN, 8'h11, 8'h22, 8'h33, 0, NONE},
      '{mf5_pkg::REQ_PIXEL, 8'hFF, 8'h00, 8'h80, 0, NONE},
      '{mf5_pkg::REQ_PIXEL, 8'hFF, 8'h00, 8'h80, 0, NONE},
      '{mf5_pkg::REQ_PIXEL, 8'hFF, 8'h00, 8'h80, 0, NONE},
      '{mf5_pkg::REQ_PIXEL, 8'hFF, 8'h00, 8'h80, 0, NONE},
      '{mf5_pkg::REQ_PIXEL, 8'hFF, 8'h00, 8'h80, 0, NONE},
      '{mf5_pkg::REQ_PIXEL, 8'hFF, 8'h00, 8'h80, 0, NONE},
      '{mf5_pkg::REQ_PIXEL, 8'hFF, 8'h00, 8'h80, 0, NONE},
      '{mf5_pkg::REQ_PIXEL, 8'hFF, 8'h00, 8'h80, 0, NONE},
      // last pixel: early output of the first position
      '{mf5_pkg::REQ_PIXEL, 8'hFF, 8'h00, 8'h80, 1, FLAT},
      // pixel during the tail is ignored
      '{mf5_pkg::REQ_PIXEL, 8'h01, 8'hFE, 8'h7F, 0, NONE},
      '{mf5_pkg::REQ_DRAIN, 8'h00, 8'h00, 8'h00, 1, FLAT},
      '{mf5_pkg::REQ_DRAIN, 8'hFF, 8'hFF, 8'hFF, 1, FLAT},
      '{mf5_pkg::REQ_DRAIN, 8'h00, 8'h00, 8'h00, 1, FLAT},
      '{mf5_pkg::REQ_DRAIN, 8'h00, 8'h00, 8'h00, 1, FLAT},
      '{mf5_pkg::REQ_DRAIN, 8'h00, 8'h00, 8'h00, 1, FLAT},
      '{mf5_pkg::REQ_DRAIN, 8'h00, 8'h00, 8'h00, 1, FLAT},
      '{mf5_pkg::REQ_DRAIN, 8'h00, 8'h00, 8'h00, 1, FLAT},
      '{mf5_pkg::REQ_DRAIN, 8'h00, 8'h00, 8'h00, 1, FLAT_FE},
      // tail closed again
      '{mf5_pkg::REQ_DRAIN, 8'h00, 8'h00, 8'h00, 0, NONE}
   };

   // --- main sequence ---------------------------------------------------------
   initial begin
      hold_req     = 1'b0;
      reset        = 1'b1;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      req_valid    = 1'b0;
      req_type     = mf5_pkg::REQ_PIXEL;
      req_red_in   = '0;
      req_green_in = '0;
      req_blue_in  = '0;
      width_reg    = 9'd256;
      height_reg   = 13'd256;
      frame_restart();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_reg(mf5_pkg::CSR_IMAGE_WIDTH, 13'd3);
      write_reg(mf5_pkg::CSR_IMAGE_HEIGHT, 13'd3);
      foreach (plan[i]) begin
         send_item(plan[i].typ, plan[i].r, plan[i].g, plan[i].b,
                   plan[i].known, plan[i].want);
         sender_gap();
      end
      wait_idle();

      // small frames; writes below 3 clamp up
      write_reg(mf5_pkg::CSR_IMAGE_WIDTH, 13'd5);
      write_reg(mf5_pkg::CSR_IMAGE_HEIGHT, 13'd4);
      run_frame();
      wait_idle();
      write_reg(mf5_pkg::CSR_IMAGE_WIDTH, 13'd0);
      write_reg(mf5_pkg::CSR_IMAGE_HEIGHT, 13'd0);
      run_frame();
      wait_idle();

      // upper bits of the width write fall away; height wraps the line slots;
      // receiver holds off while results flow, so the block fills and stalls
      write_reg(mf5_pkg::CSR_IMAGE_WIDTH, 13'h1007);
      write_reg(mf5_pkg::CSR_IMAGE_HEIGHT, 13'd12);
      hold_req = 1'b1;
      run_frame();
      wait_idle();

      // widest row (511 clamps to 256): just past the first outputs
      write_reg(mf5_pkg::CSR_IMAGE_WIDTH, 13'd511);
      write_reg(mf5_pkg::CSR_IMAGE_HEIGHT, 13'd2);
      run_partial(620);
      wait_idle();

      // tallest frames: only a slice, then the next write restarts
      write_reg(mf5_pkg::CSR_IMAGE_WIDTH, 13'd4);
      write_reg(mf5_pkg::CSR_IMAGE_HEIGHT, 13'h1FFF);
      run_partial(60);
      wait_idle();
      write_reg(mf5_pkg::CSR_IMAGE_HEIGHT, 13'd4096);
      run_partial(45);
      wait_idle();

      // two random sizes; sometimes a partial frame first to test restart mid-frame
      repeat (2) begin
         write_reg(mf5_pkg::CSR_IMAGE_WIDTH, 13'($urandom_range(3, 10)));
         write_reg(mf5_pkg::CSR_IMAGE_HEIGHT, 13'($urandom_range(3, 6)));
         if ($urandom_range(0, 1)) begin
            run_partial($urandom_range(5, 30));
            wait_idle();
            write_reg(mf5_pkg::CSR_IMAGE_HEIGHT, height_reg);
         end
         repeat (2) run_frame();
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
